@@ sv/ufce_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufce_pkg
// Shared types, constants and helpers for the union-find cycle edge filter:
// item structs, forest node layout, controller states and datapath commands.
// ----------------------------------------------------------------------------
package ufce_pkg;

  // forest size and field widths
  localparam int MAX_VERTICES = 1024;
  localparam int VERT_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int RANK_W       = 4;
  localparam int ENDPOINT_W   = 10;
  localparam int EDGE_ID_W    = 16;
  localparam int NODE_W       = RANK_W + VERT_W;

  typedef logic [VERT_W-1:0]     vert_t;
  typedef logic [RANK_W-1:0]     rank_t;
  typedef logic [ENDPOINT_W-1:0] endpoint_t;
  typedef logic [EDGE_ID_W-1:0]  edge_id_t;

  localparam rank_t RANK_MAX = '1;

  // one forest entry as stored in the node memory
  typedef struct packed {
    rank_t rank;
    vert_t parent;
  } node_t;

  typedef struct packed {
    endpoint_t endpoint_a;
    endpoint_t endpoint_b;
    edge_id_t  edge_id;
    logic      start_graph;
  } in_item_t;

  typedef struct packed {
    edge_id_t edge_id_out;
    logic     closes_cycle;
  } out_item_t;

  // controller states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_FIND_RD,
    ST_FIND_STEP,
    ST_COMP_CHK,
    ST_COMP_WR,
    ST_LINK,
    ST_LINK_RANK,
    ST_DONE
  } ctrl_state_e;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLEAR,
    DP_FIND_ISSUE,
    DP_FIND_STEP,
    DP_COMP_READ,
    DP_COMP_WRITE,
    DP_LINK,
    DP_LINK_RANK,
    DP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   sel_b;
    logic   closes;
  } dp_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_start;
    logic in_range;
    logic clear_last;
    logic root_hit;
    logic at_root;
    logic same_root;
    logic rank_lt;
    logic rank_bump;
    logic out_free;
  } dp_stat_t;

  // endpoint lies inside the forest
  function automatic logic vert_in_range(endpoint_t v);
    return int'(v) < MAX_VERTICES;
  endfunction

  function automatic vert_t to_vert(endpoint_t v);
    return vert_t'(v);
  endfunction

endpackage

@@ sv/ufce_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufce_ram
// Generic memory with one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module ufce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ufce_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufce_dp
// Datapath: edge register, node memory, root walk and compression pointers,
// root and rank capture, link writes and the result register.
// ----------------------------------------------------------------------------
module ufce_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ufce_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ufce_pkg::out_item_t out_item_o,
  input  ufce_pkg::dp_cmd_t   cmd_i,
  output ufce_pkg::dp_stat_t  stat_o
);
  import ufce_pkg::*;

  in_item_t  item_q;
  vert_t     clr_cnt_q, clr_cnt_d;
  vert_t     root_q, cur_q;
  vert_t     ra_q, rb_q;
  rank_t     rka_q, rkb_q;
  out_item_t out_q;
  logic      out_valid_q, out_valid_d;

  vert_t     vert_sel;
  node_t     rd_node;
  logic      ram_we;
  vert_t     ram_waddr, ram_raddr;
  node_t     ram_wdata;
  logic      in_fire, out_fire;

  assign in_stall_o  = (cmd_i.op != DP_LOAD);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // endpoint of the current find phase
  assign vert_sel = cmd_i.sel_b ? to_vert(item_q.endpoint_b) : to_vert(item_q.endpoint_a);

  // node memory
  ufce_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_VERTICES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_node)
  );

  // read address select
  always_comb begin
    case (cmd_i.op)
      DP_FIND_STEP: ram_raddr = rd_node.parent;
      DP_COMP_READ: ram_raddr = cur_q;
      default:      ram_raddr = vert_sel;
    endcase
  end

  // write port: clearing sweep, path compression and linking
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = '{rank: rd_node.rank, parent: root_q};
    case (cmd_i.op)
      DP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '{rank: '0, parent: clr_cnt_q};
      end
      DP_COMP_WRITE: begin
        ram_we = 1'b1;
      end
      DP_LINK: begin
        ram_we = 1'b1;
        if (stat_o.rank_lt) begin
          ram_waddr = ra_q;
          ram_wdata = '{rank: rka_q, parent: rb_q};
        end else begin
          ram_waddr = rb_q;
          ram_wdata = '{rank: rkb_q, parent: ra_q};
        end
      end
      DP_LINK_RANK: begin
        ram_we    = 1'b1;
        ram_waddr = ra_q;
        ram_wdata = '{rank: rka_q + rank_t'(1), parent: ra_q};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // clearing sweep counter
  always_comb begin
    clr_cnt_d = clr_cnt_q;
    if (cmd_i.op == DP_CLEAR) begin
      clr_cnt_d = stat_o.clear_last ? '0 : clr_cnt_q + vert_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // edge capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item_i;
    end
  end

  // root walk, root capture and compression pointer
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_FIND_ISSUE: begin
        root_q <= vert_sel;
      end
      DP_FIND_STEP: begin
        if (stat_o.root_hit) begin
          cur_q <= vert_sel;
          if (cmd_i.sel_b) begin
            rb_q  <= root_q;
            rkb_q <= rd_node.rank;
          end else begin
            ra_q  <= root_q;
            rka_q <= rd_node.rank;
          end
        end else begin
          root_q <= rd_node.parent;
        end
      end
      DP_COMP_WRITE: begin
        cur_q <= rd_node.parent;
      end
      default: begin
        cur_q <= cur_q;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && !out_fire;
    if (cmd_i.op == DP_RESULT) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_RESULT) begin
      out_q.edge_id_out  <= item_q.edge_id;
      out_q.closes_cycle <= cmd_i.closes;
    end
  end

  // status to the controller
  always_comb begin
    stat_o.in_fire    = in_fire;
    stat_o.in_start   = in_item_i.start_graph;
    stat_o.in_range   = vert_in_range(item_q.endpoint_a) && vert_in_range(item_q.endpoint_b);
    stat_o.clear_last = (clr_cnt_q == vert_t'(MAX_VERTICES - 1));
    stat_o.root_hit   = (rd_node.parent == root_q);
    stat_o.at_root    = (cur_q == root_q);
    stat_o.same_root  = (ra_q == rb_q);
    stat_o.rank_lt    = (rka_q < rkb_q);
    stat_o.rank_bump  = (rka_q == rkb_q) && (rka_q != RANK_MAX);
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

@@ sv/ufce_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufce_ctrl
// Controller: sequences clearing, the two root finds with path compression,
// the link by rank and the result hand-off.
// ----------------------------------------------------------------------------
module ufce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ufce_pkg::dp_stat_t stat_i,
  output ufce_pkg::dp_cmd_t  cmd_o
);
  import ufce_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        phase_b_q, phase_b_d;
  logic        cyc_q, cyc_d;

  // next state
  always_comb begin
    state_d   = state_q;
    phase_b_d = phase_b_q;
    cyc_d     = cyc_q;
    case (state_q)
      ST_INIT: begin
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        phase_b_d = 1'b0;
        if (stat_i.in_fire) begin
          state_d = stat_i.in_start ? ST_CLEAR : ST_FIND_RD;
        end
      end
      ST_CLEAR: begin
        if (stat_i.clear_last) begin
          state_d = ST_FIND_RD;
        end
      end
      ST_FIND_RD: begin
        if (!stat_i.in_range) begin
          cyc_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_FIND_STEP;
        end
      end
      ST_FIND_STEP: begin
        if (stat_i.root_hit) begin
          state_d = ST_COMP_CHK;
        end
      end
      ST_COMP_CHK: begin
        if (!stat_i.at_root) begin
          state_d = ST_COMP_WR;
        end else if (phase_b_q) begin
          state_d = ST_LINK;
        end else begin
          phase_b_d = 1'b1;
          state_d   = ST_FIND_RD;
        end
      end
      ST_COMP_WR: begin
        state_d = ST_COMP_CHK;
      end
      ST_LINK: begin
        cyc_d = stat_i.same_root;
        if (!stat_i.same_root && !stat_i.rank_lt && stat_i.rank_bump) begin
          state_d = ST_LINK_RANK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_LINK_RANK: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o.sel_b  = phase_b_q;
    cmd_o.closes = cyc_q;
    case (state_q)
      ST_INIT:      cmd_o.op = DP_CLEAR;
      ST_IDLE:      cmd_o.op = DP_LOAD;
      ST_CLEAR:     cmd_o.op = DP_CLEAR;
      ST_FIND_RD:   cmd_o.op = stat_i.in_range ? DP_FIND_ISSUE : DP_NOP;
      ST_FIND_STEP: cmd_o.op = DP_FIND_STEP;
      ST_COMP_CHK:  cmd_o.op = DP_COMP_READ;
      ST_COMP_WR:   cmd_o.op = DP_COMP_WRITE;
      ST_LINK:      cmd_o.op = stat_i.same_root ? DP_NOP : DP_LINK;
      ST_LINK_RANK: cmd_o.op = DP_LINK_RANK;
      ST_DONE:      cmd_o.op = stat_i.out_free ? DP_RESULT : DP_NOP;
      default:      cmd_o.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      phase_b_q <= 1'b0;
      cyc_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_b_q <= phase_b_d;
      cyc_q     <= cyc_d;
    end
  end

endmodule

@@ sv/union_find_cycle_edge_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_cycle_edge_filter
// Union-find with rank and path compression over a presorted edge stream;
// each edge is reported as merging two trees or closing a cycle.
//
//   channel  direction  signals                        payload
//   in       input      in_valid_i / in_stall_o        in_item_i  (in_item_t)
//   out      output     out_valid_o / out_stall_i      out_item_o (out_item_t)
//
// One edge at a time. The time from an edge's transfer to the next input
// slot grows with each parent hop, each compressed vertex and a rank growth,
// set by the single node memory doing one read and one write per cycle. An
// edge with an endpoint outside the forest is reported as closing a cycle.
// After reset, and for an edge with start_graph set, a clearing pass writes
// all MAX_VERTICES entries before the forest is used.
// The result register lets the next edge be taken while a result is stalled.
// ----------------------------------------------------------------------------
module union_find_cycle_edge_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ufce_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ufce_pkg::out_item_t out_item_o
);
  import ufce_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller
  ufce_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // datapath
  ufce_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  // a new graph always starts with a clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_item_i.start_graph) |=> cmd.op == DP_CLEAR)
    else $error("start of graph not followed by clearing pass");

  // a result is only loaded when the result register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == DP_RESULT) |-> stat.out_free)
    else $error("result loaded over a pending result");

  // output valid only rises from a result load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.op == DP_RESULT))
    else $error("output valid without result load");

  // rank increment only directly after a link
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == DP_LINK_RANK) |-> $past(cmd.op == DP_LINK))
    else $error("rank increment without link");

endmodule
